[sv/tbct_pkg.sv]
// ----------------------------------------------------------------------------
// Blob centroid tracker package
// Shared widths, register codes, sequencer states and the pixel and result
// structures used by the tracker and its divider and filter units.
// ----------------------------------------------------------------------------
package tbct_pkg;

	// Coordinate and fixed-point widths.
	localparam int COORD_BITS = 12;
	localparam int FRAC_BITS  = 8;
	localparam int PIX_BITS   = 8;
	localparam int AREA_BITS  = 24;
	localparam int GAIN_BITS  = 8;
	localparam int GAIN_W     = GAIN_BITS + 1;
	localparam int GAIN_ONE   = 1 << GAIN_BITS;

	// Accumulator widths: the count saturates, so the sums never overflow.
	localparam int COUNT_BITS = 2 * COORD_BITS + 1;
	localparam int SUM_BITS   = COUNT_BITS + COORD_BITS;
	localparam int FILT_BITS  = COORD_BITS + FRAC_BITS;

	// Configuration port.
	localparam int ADDR_BITS = 4;
	localparam int DATA_BITS = 32;

	// Register reset values.
	localparam logic [PIX_BITS-1:0]  LEVEL_RST = PIX_BITS'(200);
	localparam logic [AREA_BITS-1:0] AREA_RST  = AREA_BITS'(10);
	localparam logic [GAIN_W-1:0]    GAIN_RST  = GAIN_W'(128);

	// Register indexes (word address).
	typedef enum logic [1:0] {
		REG_LEVEL = 2'd0,
		REG_AREA  = 2'd1,
		REG_GAIN  = 2'd2
	} reg_idx_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_ACC,
		ST_DSTART,
		ST_DIV,
		ST_MUL,
		ST_UPD,
		ST_OUT
	} state_t;

	// One input pixel.
	typedef struct packed {
		logic [PIX_BITS-1:0]   pixel_value;
		logic [COORD_BITS-1:0] column;
		logic [COORD_BITS-1:0] row;
		logic                  frame_end;
	} pix_t;

	// One frame result.
	typedef struct packed {
		logic                  found;
		logic [COORD_BITS-1:0] centroid_x;
		logic [COORD_BITS-1:0] centroid_y;
		logic [FILT_BITS-1:0]  smoothed_x;
		logic [FILT_BITS-1:0]  smoothed_y;
	} res_t;

endpackage

[sv/tbct_div.sv]
// ----------------------------------------------------------------------------
// Blob centroid divider
// Restoring divider that produces one quotient bit per cycle. The quotient is
// known to fit in COORD_BITS bits, so only that many steps are run.
// ----------------------------------------------------------------------------
module tbct_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [tbct_pkg::SUM_BITS-1:0]    dividend,
	input  logic [tbct_pkg::COUNT_BITS-1:0]  divisor,
	output logic                             busy,
	output logic                             done,
	output logic [tbct_pkg::COORD_BITS-1:0]  quotient
);

	localparam int CB       = tbct_pkg::COORD_BITS;
	localparam int NB       = tbct_pkg::COUNT_BITS;
	localparam int SB       = tbct_pkg::SUM_BITS;
	localparam int CNT_BITS = $clog2(CB + 1);

	logic [NB-1:0]       rem_q;
	logic [CB-1:0]       quo_q;
	logic [NB-1:0]       div_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                busy_q;
	logic                done_q;

	logic [NB:0] trial;
	logic [NB:0] diff;
	logic        fits;

	// One restoring step: bring down the next dividend bit and try a subtract.
	always_comb begin
		trial = {rem_q, quo_q[CB-1]};
		diff  = trial - {1'b0, div_q};
		fits  = trial >= {1'b0, div_q};
	end

	// Step counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_BITS'(CB);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_BITS'(1);
			if (cnt_q == CNT_BITS'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Partial remainder and dividend/quotient shift register.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[SB-1:CB];
			quo_q <= dividend[CB-1:0];
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[NB-1:0] : trial[NB-1:0];
			quo_q <= {quo_q[CB-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

[sv/tbct_filt.sv]
// ----------------------------------------------------------------------------
// Blob centroid smoothing filter
// Exponential filter step f' = f + round((a * (P - f)) / 256), computed with
// one shared multiplier and a register after the product.
// ----------------------------------------------------------------------------
module tbct_filt (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [tbct_pkg::GAIN_W-1:0]     gain,
	input  logic [tbct_pkg::FILT_BITS-1:0]  target,
	input  logic [tbct_pkg::FILT_BITS-1:0]  filt,
	output logic                            valid,
	output logic [tbct_pkg::FILT_BITS-1:0]  filt_new
);

	localparam int FB        = tbct_pkg::FILT_BITS;
	localparam int DIFF_BITS = FB + 1;
	localparam int PROD_BITS = DIFF_BITS + tbct_pkg::GAIN_W + 1;
	localparam logic signed [PROD_BITS-1:0] ROUND = PROD_BITS'(tbct_pkg::GAIN_ONE / 2);

	logic signed [DIFF_BITS-1:0]        diff;
	logic signed [tbct_pkg::GAIN_W:0]   gain_s;
	logic signed [PROD_BITS-1:0]        prod;
	logic signed [PROD_BITS-1:0]        prod_s1;
	logic [FB-1:0]                      filt_s1;
	logic                               valid_s1;
	logic signed [PROD_BITS-1:0]        step;
	logic signed [PROD_BITS-1:0]        sum;

	// Signed distance from the old state to the target, scaled by the gain.
	always_comb begin
		diff   = $signed({1'b0, target}) - $signed({1'b0, filt});
		gain_s = $signed({1'b0, gain});
		prod   = diff * gain_s;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			prod_s1 <= prod;
			filt_s1 <= filt;
		end
	end

	// Round half up, drop the gain fraction and add back the old state.
	always_comb begin
		step = (prod_s1 + ROUND) >>> tbct_pkg::GAIN_BITS;
		sum  = $signed(PROD_BITS'(filt_s1)) + step;
	end

	assign valid    = valid_s1;
	assign filt_new = sum[FB-1:0];

endmodule

[sv/threshold_blob_centroid_tracker_unit.sv]
// Ordinary pixels: one transfer per cycle while no frame result is being worked out, result-free.
// Frame-end pixel with a blob: the result is set by the one-bit-per-cycle
// divider run once per axis, then the shared filter multiplier; no pixel is
// taken until the result is registered. Frame-end pixel without a blob: the
// result skips the divider and the filter.
// Reset clears the sums, the filter state and the control; registers reload.
// ----------------------------------------------------------------------------
// Threshold blob centroid tracker
// Accumulates blob pixel count and coordinate sums over a frame; above the area
// setting it divides for the centroid and applies exponential smoothing per axis.
// ----------------------------------------------------------------------------
module threshold_blob_centroid_tracker_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	// Configuration port
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [tbct_pkg::ADDR_BITS-1:0]  paddr,
	input  logic [tbct_pkg::DATA_BITS-1:0]  pwdata,
	output logic [tbct_pkg::DATA_BITS-1:0]  prdata,
	output logic                            pready,
	// Pixel stream
	input  logic                            pixel_valid,
	output logic                            pixel_ready,
	input  tbct_pkg::pix_t                  pixel,
	// Frame results
	output logic                            result_valid,
	input  logic                            result_ready,
	output tbct_pkg::res_t                  result
);

	localparam int CB = tbct_pkg::COORD_BITS;
	localparam int FB = tbct_pkg::FILT_BITS;
	localparam int NB = tbct_pkg::COUNT_BITS;
	localparam int SB = tbct_pkg::SUM_BITS;
	localparam int GW = tbct_pkg::GAIN_W;
	localparam int DB = tbct_pkg::DATA_BITS;

	tbct_pkg::state_t state_q, state_d;

	logic [tbct_pkg::PIX_BITS-1:0]  level_q;
	logic [tbct_pkg::AREA_BITS-1:0] area_q;
	logic [GW-1:0]                  gain_q;

	logic [NB-1:0] count_q;
	logic [SB-1:0] col_sum_q;
	logic [SB-1:0] row_sum_q;
	logic [FB-1:0] fx_q;
	logic [FB-1:0] fy_q;
	logic [CB-1:0] cx_q;
	logic [CB-1:0] cy_q;
	logic          found_q;
	logic          axis_q;

	tbct_pkg::res_t res_q;
	logic           res_valid_q;

	logic          cfg_wr;
	logic          pix_acc;
	logic          blob_hit;
	logic [NB-1:0] count_nxt;
	logic          found_now;
	logic          out_free;
	logic          div_start;
	logic          filt_start;
	logic          out_load;
	logic          div_busy;
	logic          div_done;
	logic [CB-1:0] quot;
	logic          filt_valid;
	logic [FB-1:0] filt_new;
	logic [GW-1:0] gain_eff;
	logic [CB-1:0] cent_sel;
	logic [FB-1:0] filt_sel;

	// Configuration writes and reads.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= tbct_pkg::LEVEL_RST;
			area_q  <= tbct_pkg::AREA_RST;
			gain_q  <= tbct_pkg::GAIN_RST;
		end else if (cfg_wr) begin
			unique case (tbct_pkg::reg_idx_t'(paddr[3:2]))
				tbct_pkg::REG_LEVEL: level_q <= pwdata[tbct_pkg::PIX_BITS-1:0];
				tbct_pkg::REG_AREA:  area_q  <= pwdata[tbct_pkg::AREA_BITS-1:0];
				tbct_pkg::REG_GAIN:  gain_q  <= pwdata[GW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (tbct_pkg::reg_idx_t'(paddr[3:2]))
			tbct_pkg::REG_LEVEL: prdata = DB'(level_q);
			tbct_pkg::REG_AREA:  prdata = DB'(area_q);
			tbct_pkg::REG_GAIN:  prdata = DB'(gain_q);
			default:             prdata = '0;
		endcase
	end

	// Blob test and the count including the current pixel.
	always_comb begin
		pix_acc   = pixel_valid && pixel_ready;
		blob_hit  = (pixel.pixel_value >= level_q) && !(&count_q);
		count_nxt = blob_hit ? count_q + NB'(1) : count_q;
		found_now = count_nxt > NB'(area_q);
		out_free  = !res_valid_q || result_ready;
	end

	// Frame accumulators, cleared when the frame result is registered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			col_sum_q <= '0;
			row_sum_q <= '0;
		end else if (out_load) begin
			count_q   <= '0;
			col_sum_q <= '0;
			row_sum_q <= '0;
		end else if (pix_acc && blob_hit) begin
			count_q   <= count_nxt;
			col_sum_q <= col_sum_q + SB'(pixel.column);
			row_sum_q <= row_sum_q + SB'(pixel.row);
		end
	end

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tbct_pkg::ST_ACC;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tbct_pkg::ST_ACC: begin
				if (pix_acc && pixel.frame_end) begin
					state_d = found_now ? tbct_pkg::ST_DSTART : tbct_pkg::ST_OUT;
				end
			end
			tbct_pkg::ST_DSTART: state_d = tbct_pkg::ST_DIV;
			tbct_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = tbct_pkg::ST_MUL;
				end
			end
			tbct_pkg::ST_MUL: state_d = tbct_pkg::ST_UPD;
			tbct_pkg::ST_UPD: state_d = axis_q ? tbct_pkg::ST_OUT : tbct_pkg::ST_DSTART;
			tbct_pkg::ST_OUT: begin
				if (out_free) begin
					state_d = tbct_pkg::ST_ACC;
				end
			end
			default: state_d = tbct_pkg::ST_ACC;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		pixel_ready = 1'b0;
		div_start   = 1'b0;
		filt_start  = 1'b0;
		out_load    = 1'b0;
		unique case (state_q)
			tbct_pkg::ST_ACC:    pixel_ready = 1'b1;
			tbct_pkg::ST_DSTART: div_start   = 1'b1;
			tbct_pkg::ST_MUL:    filt_start  = 1'b1;
			tbct_pkg::ST_OUT:    out_load    = out_free;
			default: ;
		endcase
	end

	// Frame flags: found decision and the axis being worked on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			axis_q  <= 1'b0;
		end else if (pix_acc && pixel.frame_end) begin
			found_q <= found_now;
			axis_q  <= 1'b0;
		end else if (state_q == tbct_pkg::ST_UPD) begin
			axis_q <= !axis_q;
		end
	end

	// Shared divider, run once for columns and once for rows.
	tbct_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (axis_q ? row_sum_q : col_sum_q),
		.divisor  (count_q),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (quot)
	);

	always_ff @(posedge clk) begin
		if (div_done) begin
			if (axis_q) begin
				cy_q <= quot;
			end else begin
				cx_q <= quot;
			end
		end
	end

	// Shared filter step; a gain above one is taken as one.
	always_comb begin
		gain_eff = gain_q[GW-1] ? GW'(tbct_pkg::GAIN_ONE) : gain_q;
		cent_sel = axis_q ? cy_q : cx_q;
		filt_sel = axis_q ? fy_q : fx_q;
	end

	tbct_filt u_filt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (filt_start),
		.gain     (gain_eff),
		.target   ({cent_sel, tbct_pkg::FRAC_BITS'(0)}),
		.filt     (filt_sel),
		.valid    (filt_valid),
		.filt_new (filt_new)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fx_q <= '0;
			fy_q <= '0;
		end else if (filt_valid) begin
			if (axis_q) begin
				fy_q <= filt_new;
			end else begin
				fx_q <= filt_new;
			end
		end
	end

	// Result register: holds a finished transfer until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_load) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			res_q.found      <= found_q;
			res_q.centroid_x <= found_q ? cx_q : '0;
			res_q.centroid_y <= found_q ? cy_q : '0;
			res_q.smoothed_x <= fx_q;
			res_q.smoothed_y <= fy_q;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	// The divider raises done on schedule after each start.
	a_div_latency: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> ##(CB + 1) div_done)
		else $error("divider did not finish on time");

	// No pixel is taken while a division is running.
	a_no_pix_busy: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> !pixel_ready)
		else $error("pixel taken during division");

	// The filter only updates on a frame with a blob, and only in its step.
	a_filt_found: assert property (@(posedge clk) disable iff (!arst_n)
		filt_valid |-> (state_q == tbct_pkg::ST_UPD) && found_q)
		else $error("filter update outside a found frame");

	// A result without a blob carries a zero centroid.
	a_zero_cent: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res_q.found |-> res_q.centroid_x == '0 && res_q.centroid_y == '0)
		else $error("nonzero centroid on a not-found result");

endmodule

[verif/threshold_blob_centroid_tracker_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Blob centroid tracker testbench
// Streams short frames of pixels through the tracker under changing register
// settings and random handshake gaps. A local model of the tracker predicts
// one result per frame end, which is compared field by field with what the
// block delivers.
// ----------------------------------------------------------------------------
module threshold_blob_centroid_tracker_unit_test;

	localparam int REG_UNUSED  = 3;    // index with no register behind it
	localparam int DRAIN_WAIT  = 40;   // frame-end divide and filter, with margin
	localparam int LONG_HOLD   = 300;  // result side held off to back up the stream
	localparam int STUCK_LIMIT = 2000; // cycles without any transfer
	localparam int STREAM_LEN  = 420;  // directed plus random pixels

	typedef enum {SHADE_UNIFORM, SHADE_EDGE, SHADE_BINARY} shade_t;

	// Frame model: accumulates blob sums and holds the results still owed.
	class centroid_scoreboard;
		logic [tbct_pkg::PIX_BITS-1:0]   level;
		logic [tbct_pkg::AREA_BITS-1:0]  area;
		logic [tbct_pkg::GAIN_W-1:0]     gain;
		logic [tbct_pkg::COUNT_BITS-1:0] count;
		logic [tbct_pkg::SUM_BITS-1:0]   col_sum;
		logic [tbct_pkg::SUM_BITS-1:0]   row_sum;
		logic [tbct_pkg::FILT_BITS-1:0]  filt_col;
		logic [tbct_pkg::FILT_BITS-1:0]  filt_row;
		tbct_pkg::res_t                  frames_due[$];
		int                              errors;

		function new();
			level    = tbct_pkg::LEVEL_RST;
			area     = tbct_pkg::AREA_RST;
			gain     = tbct_pkg::GAIN_RST;
			count    = '0;
			col_sum  = '0;
			row_sum  = '0;
			filt_col = '0;
			filt_row = '0;
			errors   = 0;
		endfunction

		function void write_reg(int idx, logic [tbct_pkg::DATA_BITS-1:0] value);
			case (idx)
				tbct_pkg::REG_LEVEL: level = value[tbct_pkg::PIX_BITS-1:0];
				tbct_pkg::REG_AREA:  area  = value[tbct_pkg::AREA_BITS-1:0];
				tbct_pkg::REG_GAIN:  gain  = value[tbct_pkg::GAIN_W-1:0];
				default: ;
			endcase
		endfunction

		// One filter step: gain-weighted mix of target and state, rounded half up.
		function logic [tbct_pkg::FILT_BITS-1:0] smooth_step(
				logic [tbct_pkg::FILT_BITS-1:0] state, logic [tbct_pkg::COORD_BITS-1:0] pos);
			longint unsigned a;
			longint unsigned target;
			longint unsigned acc;
			a = (gain > tbct_pkg::GAIN_ONE) ? tbct_pkg::GAIN_ONE : gain;
			target = longint'(pos) << tbct_pkg::FRAC_BITS;
			acc = a * target + (tbct_pkg::GAIN_ONE - a) * longint'(state)
					+ (tbct_pkg::GAIN_ONE >> 1);
			return tbct_pkg::FILT_BITS'(acc >> tbct_pkg::GAIN_BITS);
		endfunction

		function void note_pixel(tbct_pkg::pix_t p);
			logic [tbct_pkg::COORD_BITS-1:0] cx;
			logic [tbct_pkg::COORD_BITS-1:0] cy;
			tbct_pkg::res_t due;
			if (p.pixel_value >= level && count != {tbct_pkg::COUNT_BITS{1'b1}}) begin
				count   = count + 1'b1;
				col_sum = col_sum + p.column;
				row_sum = row_sum + p.row;
			end
			if (!p.frame_end)
				return;
			due = '0;
			if (count > area && count != 0) begin
				cx = tbct_pkg::COORD_BITS'(col_sum / count);
				cy = tbct_pkg::COORD_BITS'(row_sum / count);
				filt_col = smooth_step(filt_col, cx);
				filt_row = smooth_step(filt_row, cy);
				due.found      = 1'b1;
				due.centroid_x = cx;
				due.centroid_y = cy;
			end
			due.smoothed_x = filt_col;
			due.smoothed_y = filt_row;
			frames_due.push_back(due);
			count   = '0;
			col_sum = '0;
			row_sum = '0;
		endfunction

		function void check_result(tbct_pkg::res_t got);
			tbct_pkg::res_t want;
			if (frames_due.size() == 0) begin
				$error("result with no frame end outstanding: %h", got);
				errors++;
				return;
			end
			want = frames_due.pop_front();
			if (got.found !== want.found) begin
				$error("found: expected %0d, got %0d", want.found, got.found);
				errors++;
			end
			if (got.centroid_x !== want.centroid_x) begin
				$error("centroid_x: expected %0d, got %0d", want.centroid_x, got.centroid_x);
				errors++;
			end
			if (got.centroid_y !== want.centroid_y) begin
				$error("centroid_y: expected %0d, got %0d", want.centroid_y, got.centroid_y);
				errors++;
			end
			if (got.smoothed_x !== want.smoothed_x) begin
				$error("smoothed_x: expected %0d, got %0d", want.smoothed_x, got.smoothed_x);
				errors++;
			end
			if (got.smoothed_y !== want.smoothed_y) begin
				$error("smoothed_y: expected %0d, got %0d", want.smoothed_y, got.smoothed_y);
				errors++;
			end
		endfunction

		function int pending();
			return frames_due.size();
		endfunction
	endclass

	logic                           clk          = 1'b0;
	logic                           arst_n       = 1'b0;
	logic                           psel         = 1'b0;
	logic                           penable      = 1'b0;
	logic                           pwrite       = 1'b0;
	logic [tbct_pkg::ADDR_BITS-1:0] paddr        = '0;
	logic [tbct_pkg::DATA_BITS-1:0] pwdata       = '0;
	logic [tbct_pkg::DATA_BITS-1:0] prdata;
	logic                           pready;
	logic                           pixel_valid  = 1'b0;
	logic                           pixel_ready;
	tbct_pkg::pix_t                 pixel        = '0;
	logic                           result_valid;
	logic                           result_ready = 1'b0;
	tbct_pkg::res_t                 result;

	centroid_scoreboard sb = new();
	int next_gap     = 0;
	int pixels_sent  = 0;
	int stuck_cycles = 0;
	bit pix_quiet    = 1'b0;
	bit hold_results = 1'b0;

	threshold_blob_centroid_tracker_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.pixel_valid  (pixel_valid),
		.pixel_ready  (pixel_ready),
		.pixel        (pixel),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Abort when neither channel has moved a transfer for too long.
	always @(posedge clk) begin
		if ((pixel_valid && pixel_ready) || (result_valid && result_ready))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("threshold_blob_centroid_tracker_unit_test: errors");
			$finish;
		end
	end

	function automatic tbct_pkg::pix_t make_pixel(int value, int col, int row, bit last);
		tbct_pkg::pix_t p;
		p.pixel_value = tbct_pkg::PIX_BITS'(value);
		p.column      = tbct_pkg::COORD_BITS'(col);
		p.row         = tbct_pkg::COORD_BITS'(row);
		p.frame_end   = last;
		return p;
	endfunction

	// Offer one pixel; valid is lowered after the transfer only if a gap follows,
	// so back-to-back pixels keep it high.
	task automatic send_pixel(input tbct_pkg::pix_t p);
		if (next_gap > 0)
			repeat (next_gap) @(posedge clk);
		pixel_valid <= 1'b1;
		pixel       <= p;
		do @(posedge clk); while (!pixel_ready);
		sb.note_pixel(p);
		pixels_sent++;
		next_gap = pix_quiet ? 0 : $urandom_range(0, 15);
		if (next_gap > 0)
			pixel_valid <= 1'b0;
	endtask

	// Stop the stream and let every owed result come back.
	task automatic wait_idle();
		if (next_gap == 0)
			pixel_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(input int idx, input logic [tbct_pkg::DATA_BITS-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= tbct_pkg::ADDR_BITS'(idx * 4);
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.write_reg(idx, value);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(input logic [tbct_pkg::PIX_BITS-1:0] lvl,
			input logic [tbct_pkg::AREA_BITS-1:0] area,
			input logic [tbct_pkg::GAIN_W-1:0] gain);
		wait_idle();
		write_reg(tbct_pkg::REG_LEVEL, tbct_pkg::DATA_BITS'(lvl));
		write_reg(tbct_pkg::REG_AREA, tbct_pkg::DATA_BITS'(area));
		write_reg(tbct_pkg::REG_GAIN, tbct_pkg::DATA_BITS'(gain));
	endtask

	// One frame of random length; pixels either scatter over the whole field or
	// cluster in a small window; values are uniform, near the threshold or 0/255.
	task automatic send_random_frame();
		int             len;
		int             t;
		int             base_c;
		int             base_r;
		bit             cluster;
		shade_t         shade;
		tbct_pkg::pix_t p;
		len     = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
		shade   = shade_t'($urandom_range(0, 2));
		cluster = 1'($urandom_range(0, 1));
		base_c  = $urandom_range(0, 4095);
		base_r  = $urandom_range(0, 4095);
		if ($urandom_range(0, 3) == 0)
			pix_quiet = !pix_quiet;
		for (int i = 0; i < len; i++) begin
			case (shade)
				SHADE_EDGE: begin
					t = sb.level + int'($urandom_range(0, 4)) - 2;
					if (t < 0)
						t = 0;
					if (t > 255)
						t = 255;
				end
				SHADE_BINARY: t = ($urandom_range(0, 3) == 0) ? 0 : 255;
				default: t = $urandom_range(0, 255);
			endcase
			if (cluster)
				p = make_pixel(t, base_c + $urandom_range(0, 15), base_r + $urandom_range(0, 15),
						i == len - 1);
			else
				p = make_pixel(t, $urandom_range(0, 4095), $urandom_range(0, 4095), i == len - 1);
			send_pixel(p);
		end
	endtask

	task automatic random_phase();
		logic [tbct_pkg::PIX_BITS-1:0]  lvl;
		logic [tbct_pkg::AREA_BITS-1:0] area;
		logic [tbct_pkg::GAIN_W-1:0]    gain;
		case ($urandom_range(0, 5))
			0: lvl = '0;
			1: lvl = '1;
			default: lvl = tbct_pkg::PIX_BITS'($urandom_range(32, 240));
		endcase
		case ($urandom_range(0, 7))
			0: area = '1;
			1: area = tbct_pkg::AREA_BITS'($urandom);
			2: area = '0;
			default: area = tbct_pkg::AREA_BITS'($urandom_range(0, 8));
		endcase
		case ($urandom_range(0, 7))
			0: gain = '0;
			1: gain = tbct_pkg::GAIN_W'(tbct_pkg::GAIN_ONE);
			2: gain = tbct_pkg::GAIN_W'($urandom_range(257, 511));
			default: gain = tbct_pkg::GAIN_W'($urandom_range(1, 255));
		endcase
		set_config(lvl, area, gain);
		repeat ($urandom_range(3, 8)) send_random_frame();
	endtask

	// Result side: random stalls, quiet stretches, and one long hold-off.
	initial begin : result_sink
		int stall;
		bit quiet;
		quiet = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 7) == 0)
				quiet = !quiet;
			stall = quiet ? 0 : $urandom_range(0, 15);
			if (hold_results) begin
				stall = LONG_HOLD;
				hold_results = 1'b0;
			end
			if (stall > 0) begin
				result_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ready <= 1'b1;
			do @(posedge clk); while (!result_valid);
			sb.check_result(result);
		end
	end

	initial begin : stimulus
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: a lone bright pixel stays under the area, then a frame of
		// corner pixels at or above the threshold whose last pixel sits just below it.
		send_pixel(make_pixel(255, 4095, 4095, 1'b1));
		for (int i = 0; i < 11; i++)
			send_pixel(make_pixel((i % 2) ? 200 : 255, (i & 1) ? 4095 : 0,
					(i & 2) ? 4095 : 0, 1'b0));
		send_pixel(make_pixel(199, 4095, 4095, 1'b1));

		// Everything is blob, zero area, gain above one.
		set_config('0, '0, '1);
		send_pixel(make_pixel(0, 4095, 0, 1'b1));

		// Only full-scale pixels count, gain zero freezes the filter; a write to the
		// unused index must change nothing. An empty frame is never found.
		set_config('1, '0, '0);
		write_reg(REG_UNUSED, $urandom);
		for (int i = 0; i < 3; i++)
			send_pixel(make_pixel(254, 4095 - i, i, i == 2));
		send_pixel(make_pixel(255, 17, 4000, 1'b0));
		send_pixel(make_pixel(255, 18, 4001, 1'b1));

		// Largest area is not exceeded by this short frame; gain of exactly one.
		set_config(8'd128, '1, tbct_pkg::GAIN_W'(tbct_pkg::GAIN_ONE));
		for (int i = 0; i < 3; i++)
			send_pixel(make_pixel(255, 100 * i, 200 * i, i == 2));

		// Random phases; the first one backs up against a stalled result side.
		hold_results = 1'b1;
		while (pixels_sent < STREAM_LEN)
			random_phase();

		wait_idle();
		if (sb.errors == 0)
			$display("threshold_blob_centroid_tracker_unit_test: clean");
		else
			$display("threshold_blob_centroid_tracker_unit_test: errors");
		$finish;
	end

endmodule

[filelist.f]
sv/tbct_pkg.sv
sv/tbct_div.sv
sv/tbct_filt.sv
sv/threshold_blob_centroid_tracker_unit.sv
verif/threshold_blob_centroid_tracker_unit_test.sv
